// File: rtl/rkis_pkg.sv
package rkis_pkg;

    // Width of the values, the divisor and the keys.
    localparam int VAL_W = 30;
    // Width of the 1-based index carried by a result.
    localparam int OUT_IDX_W = 7;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             batch_end;
    } t_in_req;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] item_index;
        logic [VAL_W-1:0]     item_key;
        logic                 last_result;
        logic                 overflow;
    } t_out_res;

    // Handoff from the serial residue unit to the batch controller.
    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] key;
    } t_mod_res;

endpackage

// File: rtl/rkis_mod.sv
// Bit-serial residue unit: restoring division, one quotient bit per cycle.
module rkis_mod
    import rkis_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_value,
    input  logic [VAL_W-1:0] i_div,
    output t_mod_res         o_res
);

    localparam int STEP_W = $clog2(VAL_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [VAL_W-1:0]  r_q;
    logic [VAL_W-1:0]  r_rem;
    logic [VAL_W-1:0]  r_div;
    logic [VAL_W-1:0]  r_key;

    logic [VAL_W:0]   w_trial;
    logic             w_ge;
    logic [VAL_W-1:0] w_rem_n;

    // Shift the next dividend bit into the partial remainder and subtract if it fits.
    assign w_trial = {r_rem, r_q[VAL_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_rem_n = w_ge ? VAL_W'(w_trial - {1'b0, r_div}) : w_trial[VAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if ((i_div == '0) || (i_value <= i_div)) begin
                    r_key  <= i_value;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_q    <= i_value;
                    r_rem  <= '0;
                    r_div  <= i_div;
                    r_step <= STEP_W'(VAL_W - 1);
                end
            end else if (r_busy) begin
                r_rem <= w_rem_n;
                r_q   <= {r_q[VAL_W-2:0], 1'b0};
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_key  <= (w_rem_n == '0) ? r_div : w_rem_n;
                end else begin
                    r_step <= r_step - STEP_W'(1);
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.key  = r_key;

endmodule

// File: rtl/residue_key_index_sorter_top.sv
// Residue key index sorter.
// Input channel: i_in_valid / o_in_stall with payload i_in_req (value, batch_end).
// Each accepted request turns its value into a key with the divisor register: the
// value itself when it is at most the divisor (or the divisor is zero), otherwise the
// remainder modulo the divisor, a zero remainder being replaced by the divisor.
// The remainder is formed bit-serially, so a stored request holds the input until the
// residue unit hands its key over, after stepping through every value bit when a
// remainder is needed; a request that arrives with the store full is dropped and
// marks the batch as overflowed.
// When the request flagged batch_end has been handled, the block emits one result
// per stored item on o_out_valid / i_out_stall: arrival index, key, a flag on the
// final result and the overflow flag. Order is key descending, ties by index
// ascending. Each result is found by a pass over the stored keys, and no new request
// is taken until the batch has drained.
// A stall on the output only holds the result register and pauses the sorter.
// The divisor is written through i_cfg_we / i_cfg_data; the user must do so only while
// idle, as the block does not enforce it. Synchronous reset sets the divisor to one and
// empties the batch; key memory is not cleared, as only current-batch entries are used.
module residue_key_index_sorter_top
    import rkis_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [VAL_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_req          i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_res         o_out_res
);

    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    // Controller states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_LAST = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]     r_state;
    logic [2:0]     n_state;
    logic [VAL_W-1:0] r_div;
    logic [CW-1:0]  r_count;
    logic           r_ovf;
    logic           r_end;

    // Key memory, written once per stored request and read once per cycle while sorting.
    logic [VAL_W-1:0] r_mem [MAX_ITEMS];
    logic [VAL_W-1:0] r_rd_data;

    // Selection pass state.
    logic [IW-1:0]    r_addr;
    logic [IW-1:0]    r_pidx;
    logic             r_pvld;
    logic [MAX_ITEMS-1:0] r_used;
    logic             r_bfound;
    logic [IW-1:0]    r_bidx;
    logic [VAL_W-1:0] r_bkey;
    logic [CW-1:0]    r_outs;

    logic             r_ovld;
    t_out_res         r_ores;

    logic     w_accept;
    logic     w_full;
    logic     w_start;
    t_mod_res w_mod;
    logic     w_addr_last;
    logic     w_take;
    logic     w_load;
    logic     w_last;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_full      = (r_count >= CW'(MAX_ITEMS));
    assign w_start     = w_accept && !w_full;
    assign w_addr_last = ((CW'(r_addr) + CW'(1)) == r_count);
    // A candidate replaces the best only on a strictly larger key, which keeps
    // the lowest index among equal keys.
    assign w_take      = r_pvld && !r_used[r_pidx] && (!r_bfound || (r_rd_data > r_bkey));
    assign w_load      = (r_state == S_EMIT) && (!r_ovld || !i_out_stall);
    assign w_last      = ((r_outs + CW'(1)) == r_count);

    rkis_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_value (i_in_req.value),
        .i_div   (r_div),
        .o_res   (w_mod)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!w_full) begin
                        n_state = S_MOD;
                    end else if (i_in_req.batch_end) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_MOD: begin
                if (w_mod.done) begin
                    n_state = r_end ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN: begin
                if (w_addr_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_state = w_last ? S_IDLE : S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_div    <= VAL_W'(1);
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_pvld   <= 1'b0;
            r_bfound <= 1'b0;
            r_ovld   <= 1'b0;
            r_used   <= '0;
            r_outs   <= '0;
            r_addr   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_div <= i_cfg_data;
            end
            if (w_accept && w_full) begin
                r_ovf <= 1'b1;
            end
            if ((r_state == S_MOD) && w_mod.done) begin
                r_count <= r_count + CW'(1);
            end
            // Start of the output run: nothing emitted yet.
            if (((r_state == S_IDLE) || (r_state == S_MOD)) && (n_state == S_SCAN)) begin
                r_used   <= '0;
                r_outs   <= '0;
                r_addr   <= '0;
                r_bfound <= 1'b0;
                r_pvld   <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                r_pvld <= 1'b1;
                r_addr <= r_addr + IW'(1);
            end else if (r_state == S_LAST) begin
                r_pvld <= 1'b0;
            end
            if (w_take) begin
                r_bfound <= 1'b1;
            end
            if (w_load) begin
                r_ovld <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_ovld <= 1'b0;
            end
            if (w_load) begin
                r_used[r_bidx] <= 1'b1;
                r_outs         <= r_outs + CW'(1);
                r_addr         <= '0;
                r_bfound       <= 1'b0;
                if (w_last) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
            end
        end
    end

    // Payload registers and key memory.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_end <= i_in_req.batch_end;
        end
        if ((r_state == S_MOD) && w_mod.done) begin
            r_mem[r_count[IW-1:0]] <= w_mod.key;
        end
        r_rd_data <= r_mem[r_addr];
        r_pidx    <= r_addr;
        if (w_take) begin
            r_bidx <= r_pidx;
            r_bkey <= r_rd_data;
        end
        if (w_load) begin
            r_ores.item_index  <= OUT_IDX_W'(r_bidx) + OUT_IDX_W'(1);
            r_ores.item_key    <= r_bkey;
            r_ores.last_result <= w_last;
            r_ores.overflow    <= r_ovf;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_res   = r_ores;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("item count exceeds the store depth");

    a_done_in_mod : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod.done |-> (r_state == S_MOD))
        else $error("residue unit finished outside the key computation state");

    a_emit_found : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_bfound)
        else $error("selection pass found no unsent item");

    a_load_from_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !$past(r_ovld)) |-> ($past(r_state) == S_EMIT))
        else $error("result register loaded outside the emit state");

    a_run_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> ((r_count == '0) && !r_ovf && (r_state == S_IDLE)))
        else $error("batch state not cleared after the final result");

endmodule
